[src/bcoo_pkg.sv]
// bcoo_pkg: shared constants for the block coo sparse matrix-vector unit
// holds request codes, block geometry and store sizing; no dependencies

package bcoo_pkg;

    // block geometry and vector store depth
    localparam int BLOCK   = 3;
    localparam int VEC_LEN = 1024;

    // store address width
    localparam int ADDR_W  = $clog2(VEC_LEN);

    // width for element index arithmetic: covers 511*3+3 and VEC_LEN itself
    localparam int CALC_W  = 17;

    // field widths
    localparam int REQ_W   = 2;
    localparam int VIDX_W  = 10;
    localparam int BIDX_W  = 9;
    localparam int SUB_W   = 2;
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 64;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE_X = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE_Y = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ACCUM   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ_Y  = 2'd3;

endpackage

[src/block_coo_sparse_matvec_top.sv]
// block_coo_sparse_matvec_top: streamed y += A*x over block coordinates
// holds the x and y stores and the read-modify-write sequencer; uses bcoo_pkg

// Usage: each input word is one request. A write of x or y does not stall
// the request side. An accumulate reads the x and y memories, registers the
// Q16.16 by Q16.16 product and writes the saturating add back into y; a read
// of y reads the y memory and then waits until the output register is freed.
// The sequence is set by the single y memory: its read data is registered
// after the address, and the multiply gets a stage of its own before the
// add, so an accumulate holds the sequencer through its read, multiply and
// add steps. Both stores power up undefined and get no clearing pass: x and y
// entries must be written before they are used. Indexes at or above VEC_LEN
// and sub-indexes at or above BLOCK turn writes and accumulates into no-ops;
// a read beyond the store returns zero. Only reads of y give a result word.

module block_coo_sparse_matvec_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bcoo_pkg::REQ_W-1:0]        i_req_type,
    input  logic [bcoo_pkg::VIDX_W-1:0]       i_vec_index,
    input  logic [bcoo_pkg::BIDX_W-1:0]       i_block_row,
    input  logic [bcoo_pkg::BIDX_W-1:0]       i_block_col,
    input  logic [bcoo_pkg::SUB_W-1:0]        i_sub_row,
    input  logic [bcoo_pkg::SUB_W-1:0]        i_sub_col,
    input  logic signed [bcoo_pkg::VAL_W-1:0] i_value,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bcoo_pkg::VIDX_W-1:0]       o_read_index,
    output logic signed [bcoo_pkg::ACC_W-1:0] o_y_value
);

    localparam int ADDR_W = bcoo_pkg::ADDR_W;
    localparam int CALC_W = bcoo_pkg::CALC_W;
    localparam int VAL_W  = bcoo_pkg::VAL_W;
    localparam int ACC_W  = bcoo_pkg::ACC_W;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_RD   = 2'd3;

    localparam logic [CALC_W-1:0] BLOCK_C = CALC_W'(bcoo_pkg::BLOCK);
    localparam logic [CALC_W-1:0] VLEN_C  = CALC_W'(bcoo_pkg::VEC_LEN);

    // stores
    logic [VAL_W-1:0] x_mem [bcoo_pkg::VEC_LEN];
    logic [ACC_W-1:0] y_mem [bcoo_pkg::VEC_LEN];

    logic [1:0]              r_state, n_state;
    logic [ADDR_W-1:0]       r_yaddr;
    logic signed [VAL_W-1:0] r_val;
    logic                    r_rd_ok;
    logic [bcoo_pkg::VIDX_W-1:0] r_rd_idx;
    logic [VAL_W-1:0]        r_x_rd;
    logic [ACC_W-1:0]        r_y_rd;
    logic signed [ACC_W-1:0] r_prod;
    logic                    r_out_valid;
    logic [bcoo_pkg::VIDX_W-1:0] r_out_idx;
    logic [ACC_W-1:0]        r_out_val;

    logic              in_acc;
    logic              out_free;
    logic [CALC_W-1:0] vidx_ext, yi, xi;
    logic              vok, sub_ok, acc_ok;
    logic [ADDR_W-1:0] vaddr;

    // memory port controls
    logic              x_we, x_re;
    logic [ADDR_W-1:0] x_waddr, x_raddr;
    logic              y_we, y_re;
    logic [ADDR_W-1:0] y_waddr, y_raddr;
    logic [ACC_W-1:0]  y_wdata;

    // saturating add
    logic [ACC_W-1:0]  sum_raw, sum_sat;
    logic              sum_ovf;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // element index arithmetic
    assign vidx_ext = CALC_W'(i_vec_index);
    assign yi       = CALC_W'(i_block_row) * BLOCK_C + CALC_W'(i_sub_row);
    assign xi       = CALC_W'(i_block_col) * BLOCK_C + CALC_W'(i_sub_col);
    assign vok      = vidx_ext < VLEN_C;
    assign vaddr    = vidx_ext[ADDR_W-1:0];
    assign sub_ok   = (CALC_W'(i_sub_row) < BLOCK_C) && (CALC_W'(i_sub_col) < BLOCK_C);
    assign acc_ok   = sub_ok && (yi < VLEN_C) && (xi < VLEN_C);

    assign sum_raw = r_y_rd + r_prod;
    assign sum_ovf = (r_y_rd[ACC_W-1] == r_prod[ACC_W-1])
                  && (sum_raw[ACC_W-1] != r_y_rd[ACC_W-1]);
    always_comb begin
        if (sum_ovf) begin
            sum_sat = r_y_rd[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sum_sat = sum_raw;
        end
    end

    // request decode and memory port steering
    always_comb begin
        n_state = r_state;
        x_we    = 1'b0;
        x_re    = 1'b0;
        y_we    = 1'b0;
        y_re    = 1'b0;
        x_waddr = vaddr;
        x_raddr = xi[ADDR_W-1:0];
        y_waddr = vaddr;
        y_raddr = yi[ADDR_W-1:0];
        y_wdata = {{(ACC_W-VAL_W-16){i_value[VAL_W-1]}}, i_value, 16'b0};
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_req_type)
                        bcoo_pkg::REQ_WRITE_X: x_we = vok;
                        bcoo_pkg::REQ_WRITE_Y: y_we = vok;
                        bcoo_pkg::REQ_ACCUM: begin
                            if (acc_ok) begin
                                x_re    = 1'b1;
                                y_re    = 1'b1;
                                n_state = S_MUL;
                            end
                        end
                        bcoo_pkg::REQ_READ_Y: begin
                            y_re    = vok;
                            y_raddr = vaddr;
                            n_state = S_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: n_state = S_ADD;
            S_ADD: begin
                // write back the saturated sum
                y_we    = 1'b1;
                y_waddr = r_yaddr;
                y_wdata = sum_sat;
                n_state = S_IDLE;
            end
            S_RD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // x store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (x_we) begin
            x_mem[x_waddr] <= i_value;
        end
        if (x_re) begin
            r_x_rd <= x_mem[x_raddr];
        end
    end

    // y store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (y_we) begin
            y_mem[y_waddr] <= y_wdata;
        end
        if (y_re) begin
            r_y_rd <= y_mem[y_raddr];
        end
    end

    // payload registers for the item in flight
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_yaddr  <= yi[ADDR_W-1:0];
            r_val    <= i_value;
            r_rd_ok  <= vok;
            r_rd_idx <= i_vec_index;
        end
        if (r_state == S_MUL) begin
            // exact q32.32 product of two q16.16 values
            r_prod <= ACC_W'(r_val) * ACC_W'($signed(r_x_rd));
        end
        if (r_state == S_RD && out_free) begin
            r_out_idx <= r_rd_idx;
            r_out_val <= r_rd_ok ? r_y_rd : '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_index = r_out_idx;
    assign o_y_value    = r_out_val;

endmodule

[src/bcoo_chk.sv]
// bcoo_chk: port-level checks for block_coo_sparse_matvec_top
// watches the top level ports only; uses bcoo_pkg, bound to the top level

module bcoo_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [bcoo_pkg::REQ_W-1:0]        i_req_type,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [bcoo_pkg::VIDX_W-1:0]       o_read_index,
    input logic signed [bcoo_pkg::ACC_W-1:0] o_y_value
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a stalled result word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_y_value) && $stable(o_read_index))
        else $error("stalled result word changed");

    // a read of y keeps the request side stalled for its result
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_req_type == bcoo_pkg::REQ_READ_Y) |=> o_in_stall)
        else $error("read accepted without holding the request side");

    // requests other than a read never raise a new result word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_req_type != bcoo_pkg::REQ_READ_Y) && !o_out_valid
        |=> !o_out_valid)
        else $error("result word without a read");

endmodule

bind block_coo_sparse_matvec_top bcoo_chk u_bcoo_chk (.*);

[verif/block_coo_sparse_matvec_top_tb.sv]
// block_coo_sparse_matvec_top_tb: self-checking testbench for the block coo matvec unit
// drives request words, predicts y readbacks from shadow x/y stores and checks each result
// depends on bcoo_pkg and block_coo_sparse_matvec_top

module block_coo_sparse_matvec_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQ_W   = bcoo_pkg::REQ_W;
    localparam int VIDX_W  = bcoo_pkg::VIDX_W;
    localparam int BIDX_W  = bcoo_pkg::BIDX_W;
    localparam int SUB_W   = bcoo_pkg::SUB_W;
    localparam int VAL_W   = bcoo_pkg::VAL_W;
    localparam int ACC_W   = bcoo_pkg::ACC_W;
    localparam int BLOCK   = bcoo_pkg::BLOCK;
    localparam int VEC_LEN = bcoo_pkg::VEC_LEN;

    // generous cap on run length, far above the slowest legal run
    localparam int CYCLE_LIMIT = 400000;
    // cycles to let the last accumulate settle after the final readback
    localparam int TAIL_CYCLES = 8;
    // mismatches printed in full before only counting
    localparam int REPORT_MAX  = 10;

    // one request word as it goes onto the input channel
    typedef struct {
        logic [REQ_W-1:0]         req;
        logic [VIDX_W-1:0]        vidx;
        logic [BIDX_W-1:0]        brow;
        logic [BIDX_W-1:0]        bcol;
        logic [SUB_W-1:0]         srow;
        logic [SUB_W-1:0]         scol;
        logic signed [VAL_W-1:0]  val;
    } t_request_word;

    // one expected readback word
    typedef struct {
        logic [VIDX_W-1:0]        index;
        logic signed [ACC_W-1:0]  value;
    } t_y_readback;

    // dut ports
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [REQ_W-1:0]            i_req_type = '0;
    logic [VIDX_W-1:0]           i_vec_index = '0;
    logic [BIDX_W-1:0]           i_block_row = '0;
    logic [BIDX_W-1:0]           i_block_col = '0;
    logic [SUB_W-1:0]            i_sub_row = '0;
    logic [SUB_W-1:0]            i_sub_col = '0;
    logic signed [VAL_W-1:0]     i_value = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [VIDX_W-1:0]           o_read_index;
    logic signed [ACC_W-1:0]     o_y_value;

    // shadow copies of the two stores plus which entries hold defined data
    logic signed [VAL_W-1:0]     x_shadow [VEC_LEN];
    logic signed [ACC_W-1:0]     y_shadow [VEC_LEN];
    bit                          x_written [VEC_LEN];
    bit                          y_written [VEC_LEN];
    // written indexes in a form that is easy to pick from at random
    int                          x_written_idx [$];
    int                          y_written_idx [$];

    // readbacks still owed by the dut, oldest first
    t_y_readback                 pending_reads [$];
    t_y_readback                 oldest;

    int                          error_count = 0;
    int                          cycle_count = 0;
    // idle rates in percent, changed per traffic phase
    int                          src_idle_pct = 0;
    int                          sink_stall_pct = 0;

    block_coo_sparse_matvec_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_vec_index  (i_vec_index),
        .i_block_row  (i_block_row),
        .i_block_col  (i_block_col),
        .i_sub_row    (i_sub_row),
        .i_sub_col    (i_sub_col),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_index (o_read_index),
        .o_y_value    (o_y_value)
    );

    // 2 ns clock
    always #1 i_clk = ~i_clk;

    // run-length guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("block_coo_sparse_matvec_top_tb: done, errors");
            $finish;
        end
    end

    // receiver back-pressure, changed only on the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < sink_stall_pct);
    end

    // Q32.32 add that clamps at the signed 64-bit limits
    function automatic logic signed [ACC_W-1:0] add_saturated(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W-1:0] s;
        s = a + b;
        // same-sign operands whose sum flips sign have overflowed
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
            return a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s;
    endfunction

    // update the shadow stores for one accepted word and queue any readback it owes
    function automatic void apply_request(input t_request_word w);
        int                      yi;
        int                      xi;
        logic signed [ACC_W-1:0] mv;
        logic signed [ACC_W-1:0] xv;
        t_y_readback             rb;
        case (w.req)
            bcoo_pkg::REQ_WRITE_X: begin
                if (!x_written[w.vidx]) begin
                    x_written[w.vidx] = 1'b1;
                    x_written_idx.push_back(int'(w.vidx));
                end
                x_shadow[w.vidx] = w.val;
            end
            bcoo_pkg::REQ_WRITE_Y: begin
                if (!y_written[w.vidx]) begin
                    y_written[w.vidx] = 1'b1;
                    y_written_idx.push_back(int'(w.vidx));
                end
                // Q16.16 widened to Q32.32
                y_shadow[w.vidx] = {{16{w.val[VAL_W-1]}}, w.val, 16'h0000};
            end
            bcoo_pkg::REQ_ACCUM: begin
                yi = int'(w.brow) * BLOCK + int'(w.srow);
                xi = int'(w.bcol) * BLOCK + int'(w.scol);
                // sub-index past the block edge or element past the store: no-op
                if (w.srow < BLOCK && w.scol < BLOCK && yi < VEC_LEN && xi < VEC_LEN) begin
                    mv = w.val;
                    xv = x_shadow[xi];
                    y_shadow[yi] = add_saturated(y_shadow[yi], mv * xv);
                end
            end
            default: begin
                rb.index = w.vidx;
                rb.value = (int'(w.vidx) < VEC_LEN) ? y_shadow[w.vidx] : '0;
                pending_reads.push_back(rb);
            end
        endcase
    endfunction

    // word addressed by vector index; unused fields carry random noise
    function automatic t_request_word vec_word(
        input logic [REQ_W-1:0]        req,
        input int                      idx,
        input logic signed [VAL_W-1:0] val
    );
        t_request_word w;
        w.req  = req;
        w.vidx = idx[VIDX_W-1:0];
        w.brow = BIDX_W'($urandom_range(511));
        w.bcol = BIDX_W'($urandom_range(511));
        w.srow = SUB_W'($urandom_range(3));
        w.scol = SUB_W'($urandom_range(3));
        w.val  = val;
        return w;
    endfunction

    // accumulate word targeting y[yi] += val * x[xi]
    function automatic t_request_word accum_word(
        input int                      yi,
        input int                      xi,
        input logic signed [VAL_W-1:0] val
    );
        t_request_word w;
        w.req  = bcoo_pkg::REQ_ACCUM;
        w.vidx = VIDX_W'($urandom_range(1023));
        w.brow = BIDX_W'(yi / BLOCK);
        w.srow = SUB_W'(yi % BLOCK);
        w.bcol = BIDX_W'(xi / BLOCK);
        w.scol = SUB_W'(xi % BLOCK);
        w.val  = val;
        return w;
    endfunction

    // random Q16.16 value: full range, small magnitudes or the extremes
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            1: begin
                case ($urandom_range(3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    default: return 32'shFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // present one word at the falling edge and hold it until accepted
    task automatic send_word(input t_request_word w);
        // random idle cycles ahead of the word
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_req_type  <= w.req;
        i_vec_index <= w.vidx;
        i_block_row <= w.brow;
        i_block_col <= w.bcol;
        i_sub_row   <= w.srow;
        i_sub_col   <= w.scol;
        i_value     <= w.val;
        do @(posedge i_clk); while (o_in_stall);
        apply_request(w);
    endtask

    // stop sending and wait until every owed readback has come back
    task automatic wait_reads_returned();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
    endtask

    // result checker: each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reads.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected result word: index %0d y %h", o_read_index, o_y_value);
            end else begin
                oldest = pending_reads.pop_front();
                if (o_read_index !== oldest.index || o_y_value !== oldest.value) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("readback mismatch: index exp %0d got %0d, y exp %h got %h",
                                 oldest.index, o_read_index, oldest.value, o_y_value);
                end
            end
        end
    end

    // extreme values into x and y, then read y back to check the widening
    task automatic test_write_read_extremes();
        send_word(vec_word(bcoo_pkg::REQ_WRITE_X, 0, 32'sh7FFF_FFFF));
        send_word(vec_word(bcoo_pkg::REQ_WRITE_X, 1, 32'sh8000_0000));
        send_word(vec_word(bcoo_pkg::REQ_WRITE_X, VEC_LEN - 1, 32'sh0001_0000));
        send_word(vec_word(bcoo_pkg::REQ_WRITE_Y, 0, 32'sh7FFF_FFFF));
        send_word(vec_word(bcoo_pkg::REQ_WRITE_Y, 1, 32'sh8000_0000));
        send_word(vec_word(bcoo_pkg::REQ_WRITE_Y, VEC_LEN - 1, 32'shFFFF_FFFF));
        send_word(vec_word(bcoo_pkg::REQ_READ_Y, 0, 32'sh0));
        send_word(vec_word(bcoo_pkg::REQ_READ_Y, 1, 32'sh0));
        send_word(vec_word(bcoo_pkg::REQ_READ_Y, VEC_LEN - 1, 32'sh0));
    endtask

    // accumulator clamping at both limits, plus a plain in-range product
    task automatic test_saturation();
        // y[0] climbs by about 2^62 per step: fine once, clamps on the second
        send_word(accum_word(0, 0, 32'sh7FFF_FFFF));
        send_word(vec_word(bcoo_pkg::REQ_READ_Y, 0, 32'sh0));
        send_word(accum_word(0, 0, 32'sh7FFF_FFFF));
        send_word(accum_word(0, 0, 32'sh7FFF_FFFF));
        send_word(vec_word(bcoo_pkg::REQ_READ_Y, 0, 32'sh0));
        // y[1] falls by about 2^62 per step and clamps at the bottom
        send_word(accum_word(1, 1, 32'sh7FFF_FFFF));
        send_word(accum_word(1, 1, 32'sh7FFF_FFFF));
        send_word(accum_word(1, 1, 32'sh7FFF_FFFF));
        send_word(vec_word(bcoo_pkg::REQ_READ_Y, 1, 32'sh0));
        // last element of both stores: 2.0 times 1.0
        send_word(accum_word(VEC_LEN - 1, VEC_LEN - 1, 32'sh0002_0000));
        send_word(vec_word(bcoo_pkg::REQ_READ_Y, VEC_LEN - 1, 32'sh0));
    endtask

    // accumulates that must leave y untouched
    task automatic test_ignored_requests();
        t_request_word w;
        // column sub-index past the block edge
        w = accum_word(VEC_LEN - 1, VEC_LEN - 1, 32'sh7FFF_FFFF);
        w.scol = 2'd3;
        send_word(w);
        // row sub-index past the block edge
        w = accum_word(VEC_LEN - 1, VEC_LEN - 1, 32'sh7FFF_FFFF);
        w.brow = 9'd340;
        w.srow = 2'd3;
        send_word(w);
        // y element beyond the store
        w = accum_word(VEC_LEN - 1, VEC_LEN - 1, 32'sh7FFF_FFFF);
        w.brow = 9'd511;
        w.srow = 2'd2;
        send_word(w);
        // x element beyond the store
        w = accum_word(VEC_LEN - 1, VEC_LEN - 1, 32'sh7FFF_FFFF);
        w.bcol = 9'd511;
        w.scol = 2'd2;
        send_word(w);
        send_word(vec_word(bcoo_pkg::REQ_READ_Y, VEC_LEN - 1, 32'sh0));
    endtask

    // mixed traffic: vector loads, streamed matrix elements and readbacks
    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_words);
        t_request_word w;
        int            kind;
        int            yi;
        int            xi;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < n_words; i++) begin
            // halfway through, hold off until the output side has caught up
            if (i == n_words / 2)
                wait_reads_returned();
            kind = $urandom_range(99);
            if (kind < 18) begin
                w = vec_word(bcoo_pkg::REQ_WRITE_X, $urandom_range(VEC_LEN - 1),
                             pick_value());
            end else if (kind < 32) begin
                w = vec_word(bcoo_pkg::REQ_WRITE_Y, $urandom_range(VEC_LEN - 1),
                             pick_value());
            end else if (kind < 78) begin
                if (kind < 73) begin
                    // well-formed element onto defined x and y entries
                    xi = x_written_idx[$urandom_range(x_written_idx.size() - 1)];
                    yi = y_written_idx[$urandom_range(y_written_idx.size() - 1)];
                    w = accum_word(yi, xi, pick_value());
                end else begin
                    // raw coordinates; anything that would touch an undefined
                    // in-range entry is pushed past the block edge instead
                    w = vec_word(bcoo_pkg::REQ_ACCUM, $urandom_range(VEC_LEN - 1),
                                 pick_value());
                    yi = int'(w.brow) * BLOCK + int'(w.srow);
                    xi = int'(w.bcol) * BLOCK + int'(w.scol);
                    if (w.srow < BLOCK && w.scol < BLOCK && yi < VEC_LEN && xi < VEC_LEN
                        && !(x_written[xi] && y_written[yi]))
                        w.srow = 2'd3;
                end
            end else begin
                w = vec_word(bcoo_pkg::REQ_READ_Y,
                             y_written_idx[$urandom_range(y_written_idx.size() - 1)],
                             $urandom);
            end
            send_word(w);
        end
    endtask

    initial begin
        // synchronous reset held low, then released on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_write_read_extremes();
        test_saturation();
        test_ignored_requests();
        // sender gaps with heavy receiver stalls, then the reverse, then flat out
        test_random_traffic(10, 60, 575);
        test_random_traffic(60, 10, 575);
        test_random_traffic(0, 0, 575);

        // drain, then give the last accumulate time to finish
        wait_reads_returned();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("block_coo_sparse_matvec_top_tb: done, clean");
        end else begin
            $display("block_coo_sparse_matvec_top_tb: done, errors");
        end
        $finish;
    end

endmodule
